### rtl/core/button_click_classifier_macros.svh
// assertion macros of the button click classifier checker
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bcc_pkg.sv
// types and constants of the button click classifier
package bcc_pkg;

	// debounce phase codes
	localparam logic [1:0] PH_IDLE        = 2'd0;
	localparam logic [1:0] PH_DEB_PRESS   = 2'd1;
	localparam logic [1:0] PH_PRESSED     = 2'd2;
	localparam logic [1:0] PH_DEB_RELEASE = 2'd3;

	// event codes
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_LONG   = 3'd1;
	localparam logic [2:0] EV_SINGLE = 3'd2;
	localparam logic [2:0] EV_DOUBLE = 3'd3;
	localparam logic [2:0] EV_TRIPLE = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MULTICLICK = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd800;
	localparam logic [CFG_DATA_W-1:0] MULTICLICK_RST = 16'd400;

	localparam logic [3:0] CLICKS_MAX = 4'd15;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] debounce_ticks;
		logic [CFG_DATA_W-1:0] long_press_ticks;
		logic [CFG_DATA_W-1:0] multiclick_ticks;
	} cfg_regs_t;

	// control flags of the debounce machine
	typedef struct packed {
		logic [1:0] phase;
		logic       long_reported;
		logic [3:0] clicks;
		logic       awake;
	} ctrl_t;

endpackage

### rtl/core/bcc_if.sv
// handshake channels of the button click classifier

// tick item channel
interface bcc_tick_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic edge_seen;

	modport source (output valid, output pin_level, output edge_seen, input ready);
	modport sink (input valid, input pin_level, input edge_seen, output ready);
endinterface

// result item channel
interface bcc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       polling;
	logic       held;

	modport source (output valid, output event_res, output polling, output held,
		input ready);
	modport sink (input valid, input event_res, input polling, input held,
		output ready);
endinterface

// configuration write channel
interface bcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bcc_pkg::CFG_IDX_W-1:0]    index;
	logic [bcc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/bcc_step.sv
// next-state and event logic for one tick of the debounce machine
module bcc_step #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  bcc_pkg::cfg_regs_t    cfg_regs,
	input  bcc_pkg::ctrl_t        ctrl_cur,
	input  logic [TIMER_BITS-1:0] countdown_cur,
	input  logic [TIMER_BITS-1:0] hold_cur,
	input  logic                  pin_level,
	input  logic                  edge_seen,
	output bcc_pkg::ctrl_t        ctrl_nxt,
	output logic [TIMER_BITS-1:0] countdown_nxt,
	output logic [TIMER_BITS-1:0] hold_nxt,
	output logic [2:0]            event_res,
	output logic                  held
);

	localparam logic [32:0] TMAX_W = (33'd1 << TIMER_BITS) - 33'd1;
	localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

	logic [TIMER_BITS-1:0] deb_ld;
	logic [TIMER_BITS-1:0] long_ld;
	logic [TIMER_BITS-1:0] mc_ld;

	// zero reads as one, values above the timer range saturate
	function automatic logic [32:0] clip(input logic [bcc_pkg::CFG_DATA_W-1:0] v);
		logic [32:0] w;
		w = {17'd0, v};
		if (w == 33'd0)
			w = 33'd1;
		if (w > TMAX_W)
			w = TMAX_W;
		return w;
	endfunction

	always_comb begin
		deb_ld  = TIMER_BITS'(clip(cfg_regs.debounce_ticks));
		long_ld = TIMER_BITS'(clip(cfg_regs.long_press_ticks));
		mc_ld   = TIMER_BITS'(clip(cfg_regs.multiclick_ticks));
	end

	// debounce phase update, then click run countdown
	always_comb begin
		bcc_pkg::ctrl_t        c;
		logic [TIMER_BITS-1:0] cd;
		logic [TIMER_BITS-1:0] hd;
		logic [2:0]            ev;
		c  = ctrl_cur;
		cd = countdown_cur;
		hd = hold_cur;
		ev = bcc_pkg::EV_NONE;

		if (edge_seen)
			c.awake = 1'b1;

		if (c.awake) begin
			unique case (c.phase)
				bcc_pkg::PH_IDLE: begin
					if (!pin_level) begin
						c.phase = bcc_pkg::PH_DEB_PRESS;
						cd = deb_ld;
					end
				end
				bcc_pkg::PH_DEB_PRESS: begin
					if (!pin_level) begin
						cd = cd - ONE;
						if (cd == '0) begin
							c.phase = bcc_pkg::PH_PRESSED;
							hd = '0;
							c.long_reported = 1'b0;
						end
					end else begin
						c.phase = bcc_pkg::PH_IDLE;
					end
				end
				bcc_pkg::PH_PRESSED: begin
					if (hd != '1)
						hd = hd + ONE;
					if (!c.long_reported && hd >= long_ld) begin
						c.long_reported = 1'b1;
						ev = bcc_pkg::EV_LONG;
					end
					if (pin_level) begin
						c.phase = bcc_pkg::PH_DEB_RELEASE;
						cd = deb_ld;
					end
				end
				default: begin
					if (pin_level) begin
						cd = cd - ONE;
						if (cd == '0) begin
							c.phase = bcc_pkg::PH_IDLE;
							if (!c.long_reported) begin
								if (c.clicks != bcc_pkg::CLICKS_MAX)
									c.clicks = c.clicks + 4'd1;
								cd = mc_ld;
							end else begin
								c.awake = 1'b0;
							end
						end
					end else begin
						c.phase = bcc_pkg::PH_PRESSED;
					end
				end
			endcase

			// click run timeout
			if (c.clicks != 4'd0 && c.phase == bcc_pkg::PH_IDLE && cd != '0) begin
				cd = cd - ONE;
				if (cd == '0) begin
					case (c.clicks)
						4'd1:    ev = bcc_pkg::EV_SINGLE;
						4'd2:    ev = bcc_pkg::EV_DOUBLE;
						4'd3:    ev = bcc_pkg::EV_TRIPLE;
						default: ev = bcc_pkg::EV_NONE;
					endcase
					c.clicks = 4'd0;
					c.awake = 1'b0;
				end
			end
		end

		ctrl_nxt      = c;
		countdown_nxt = cd;
		hold_nxt      = hd;
		event_res     = ev;
		held          = (c.phase == bcc_pkg::PH_PRESSED) ||
			(c.phase == bcc_pkg::PH_DEB_RELEASE);
	end

endmodule

### rtl/core/button_click_classifier.sv
// top level of the button click classifier
//
// Usage: one tick item per millisecond on the tick channel carries the raw
// active-low pin level and an edge flag. Each tick gives exactly one item on
// the result channel: the event code (none, long press, single, double,
// triple click), whether the block is still polling and whether the button
// is held. Registers are written on the cfg channel, which is always ready;
// index 0 debounce ticks, 1 long press ticks, 2 multiclick ticks. Write them
// only while no tick is in flight.
// Result: the result of a tick is registered and valid in the cycle after the tick is taken.
// Throughput: one tick per cycle while result.ready is high; the debounce state and
// the result register are both updated in the accepting cycle.
// Reset: all state returns to asleep/idle with zero counters, registers take
// 20, 800 and 400, and no result is pending.
// Stall: while the result register holds an item the receiver has not taken,
// tick.ready is low; it is high again in the cycle the item is taken.
module button_click_classifier #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	bcc_tick_if.sink            tick,
	bcc_result_if.source        result,
	bcc_cfg_if.sink             cfg
);

	bcc_pkg::cfg_regs_t    cfg_q;
	bcc_pkg::ctrl_t        ctrl_q;
	bcc_pkg::ctrl_t        ctrl_nxt;
	logic [TIMER_BITS-1:0] countdown_q;
	logic [TIMER_BITS-1:0] countdown_nxt;
	logic [TIMER_BITS-1:0] hold_q;
	logic [TIMER_BITS-1:0] hold_nxt;
	logic [2:0]            event_nxt;
	logic                  held_nxt;
	logic                  out_valid_q;
	logic [2:0]            event_q;
	logic                  polling_q;
	logic                  held_q;
	logic                  take;

	assign cfg.ready = 1'b1;
	assign tick.ready = !out_valid_q || result.ready;
	assign take = tick.valid && tick.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= bcc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ticks <= bcc_pkg::LONG_PRESS_RST;
			cfg_q.multiclick_ticks <= bcc_pkg::MULTICLICK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bcc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg.data;
				bcc_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg.data;
				bcc_pkg::REG_MULTICLICK: cfg_q.multiclick_ticks <= cfg.data;
				default: ;
			endcase
		end
	end

	// per-tick update logic
	bcc_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.cfg_regs      (cfg_q),
		.ctrl_cur      (ctrl_q),
		.countdown_cur (countdown_q),
		.hold_cur      (hold_q),
		.pin_level     (tick.pin_level),
		.edge_seen     (tick.edge_seen),
		.ctrl_nxt      (ctrl_nxt),
		.countdown_nxt (countdown_nxt),
		.hold_nxt      (hold_nxt),
		.event_res     (event_nxt),
		.held          (held_nxt)
	);

	// debounce machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.phase         <= bcc_pkg::PH_IDLE;
			ctrl_q.long_reported <= 1'b0;
			ctrl_q.clicks        <= 4'd0;
			ctrl_q.awake         <= 1'b0;
			countdown_q          <= '0;
			hold_q               <= '0;
		end else if (take) begin
			ctrl_q      <= ctrl_nxt;
			countdown_q <= countdown_nxt;
			hold_q      <= hold_nxt;
		end
	end

	// result item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result item payload
	always_ff @(posedge clk) begin
		if (take) begin
			event_q   <= event_nxt;
			polling_q <= ctrl_nxt.awake;
			held_q    <= held_nxt;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.event_res = event_q;
	assign result.polling   = polling_q;
	assign result.held      = held_q;

endmodule

### rtl/core/bcc_checker.sv
// port-level checks of the button click classifier and their binding
`include "button_click_classifier_macros.svh"

module bcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tick_valid,
	input logic       tick_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] event_res,
	input logic       polling,
	input logic       held
);

	// a pending result that is not taken stays put
	`BCC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(event_res) && $stable(polling) && $stable(held), "result item changed while stalled")

	// every taken tick gives a result item in the next cycle
	`BCC_ASSERT_NEXT(a_tick_to_res, tick_valid && tick_ready, res_valid, "tick item gave no result item")

	// an empty result register never blocks ticks
	`BCC_ASSERT_NOW(a_ready_when_empty, !res_valid, tick_ready, "tick channel stalled with no result pending")

	// a long press fires while held and awake; a click report ends polling
	`BCC_ASSERT_NOW(a_long_held, res_valid && event_res == bcc_pkg::EV_LONG, held && polling, "long press event without a held button")
	`BCC_ASSERT_NOW(a_click_sleep, res_valid && (event_res == bcc_pkg::EV_SINGLE || event_res == bcc_pkg::EV_DOUBLE || event_res == bcc_pkg::EV_TRIPLE), !polling && !held, "click report while still polling")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.event_res  (result.event_res),
	.polling    (result.polling),
	.held       (result.held)
);

### dv/tb_button_click_classifier.sv
// testbench of the button click classifier: directed and random gestures against a predictor
module tb_button_click_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned HOLD_OFF_CYCLES = 80;
	localparam int unsigned MAX_PRINTS = 20;

	typedef struct packed {
		logic [2:0] event_res;
		logic       polling;
		logic       held;
	} click_result_t;

	logic clk;
	logic arst_n;

	bcc_tick_if   tick_ch ();
	bcc_result_if res_ch ();
	bcc_cfg_if    cfg_ch ();

	button_click_classifier #(
		.TIMER_BITS(16)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the block state and registers
	bcc_pkg::cfg_regs_t m_regs;
	logic [1:0]  m_phase;
	logic [15:0] m_count;
	logic [15:0] m_hold;
	logic        m_long_done;
	logic [3:0]  m_clicks;
	logic        m_awake;

	click_result_t pending_results[$];

	int unsigned errors;
	int unsigned ticks_sent;
	int unsigned results_checked;
	int unsigned idle_cycles;
	int unsigned event_counts[5];

	// sender and receiver control
	int unsigned burst_left;
	logic        last_pin;
	bit          hold_off_req;
	int unsigned cur_deb;
	int unsigned cur_long;
	int unsigned cur_mc;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// a zero register value counts as one tick
	function automatic logic [15:0] timer_load(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// advance the predicted debounce machine by one tick
	task automatic classify_tick(input logic pin, input logic edg, output click_result_t res);
		logic [2:0] evt;
		evt = bcc_pkg::EV_NONE;
		if (!m_awake && edg)
			m_awake = 1'b1;
		if (m_awake) begin
			case (m_phase)
				bcc_pkg::PH_IDLE: begin
					if (!pin) begin
						m_phase = bcc_pkg::PH_DEB_PRESS;
						m_count = timer_load(m_regs.debounce_ticks);
					end
				end
				bcc_pkg::PH_DEB_PRESS: begin
					if (!pin) begin
						m_count = m_count - 16'd1;
						if (m_count == 16'd0) begin
							m_phase = bcc_pkg::PH_PRESSED;
							m_hold = 16'd0;
							m_long_done = 1'b0;
						end
					end else begin
						m_phase = bcc_pkg::PH_IDLE;
					end
				end
				bcc_pkg::PH_PRESSED: begin
					if (m_hold != 16'hFFFF)
						m_hold = m_hold + 16'd1;
					if (!m_long_done && m_hold >= timer_load(m_regs.long_press_ticks)) begin
						m_long_done = 1'b1;
						evt = bcc_pkg::EV_LONG;
					end
					if (pin) begin
						m_phase = bcc_pkg::PH_DEB_RELEASE;
						m_count = timer_load(m_regs.debounce_ticks);
					end
				end
				default: begin
					if (pin) begin
						m_count = m_count - 16'd1;
						if (m_count == 16'd0) begin
							m_phase = bcc_pkg::PH_IDLE;
							if (!m_long_done) begin
								if (m_clicks != bcc_pkg::CLICKS_MAX)
									m_clicks = m_clicks + 4'd1;
								m_count = timer_load(m_regs.multiclick_ticks);
							end else begin
								m_awake = 1'b0;
							end
						end
					end else begin
						m_phase = bcc_pkg::PH_PRESSED;
					end
				end
			endcase

			// click run countdown
			if (m_clicks != 4'd0 && m_phase == bcc_pkg::PH_IDLE && m_count != 16'd0) begin
				m_count = m_count - 16'd1;
				if (m_count == 16'd0) begin
					case (m_clicks)
						4'd1: evt = bcc_pkg::EV_SINGLE;
						4'd2: evt = bcc_pkg::EV_DOUBLE;
						4'd3: evt = bcc_pkg::EV_TRIPLE;
						default: evt = bcc_pkg::EV_NONE;
					endcase
					m_clicks = 4'd0;
					m_awake = 1'b0;
				end
			end
		end
		res.event_res = evt;
		res.polling = m_awake;
		res.held = (m_phase == bcc_pkg::PH_PRESSED) || (m_phase == bcc_pkg::PH_DEB_RELEASE);
	endtask

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch in %s of result %0d: got %0d, expected %0d",
				field, results_checked, got, want);
	endtask

	// monitor: predict on each accepted tick, check each accepted result
	always @(posedge clk or negedge arst_n) begin
		click_result_t want;
		click_result_t got;
		if (!arst_n) begin
			m_regs = '{bcc_pkg::DEBOUNCE_RST, bcc_pkg::LONG_PRESS_RST,
				bcc_pkg::MULTICLICK_RST};
			m_phase = bcc_pkg::PH_IDLE;
			m_count = 16'd0;
			m_hold = 16'd0;
			m_long_done = 1'b0;
			m_clicks = 4'd0;
			m_awake = 1'b0;
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (res_ch.valid && res_ch.ready) begin
				idle_cycles = 0;
				got = '{res_ch.event_res, res_ch.polling, res_ch.held};
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= MAX_PRINTS)
						$display("result item with no tick waiting for it");
				end else begin
					want = pending_results.pop_front();
					if (got.event_res !== want.event_res)
						report_mismatch("event_res", 32'(got.event_res),
							32'(want.event_res));
					if (got.polling !== want.polling)
						report_mismatch("polling", 32'(got.polling), 32'(want.polling));
					if (got.held !== want.held)
						report_mismatch("held", 32'(got.held), 32'(want.held));
					if (want.event_res <= bcc_pkg::EV_TRIPLE)
						event_counts[want.event_res]++;
				end
				results_checked++;
			end
			if (tick_ch.valid && tick_ch.ready) begin
				idle_cycles = 0;
				classify_tick(tick_ch.pin_level, tick_ch.edge_seen, want);
				pending_results.push_back(want);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				idle_cycles = 0;
				case (cfg_ch.index)
					bcc_pkg::REG_DEBOUNCE:   m_regs.debounce_ticks = cfg_ch.data;
					bcc_pkg::REG_LONG_PRESS: m_regs.long_press_ticks = cfg_ch.data;
					bcc_pkg::REG_MULTICLICK: m_regs.multiclick_ticks = cfg_ch.data;
					default: ;
				endcase
			end
		end
	end

	// receiver: changing stall pattern, plus a long hold-off on request
	initial begin
		int unsigned rcv_cycle;
		int unsigned mode;
		res_ch.ready = 1'b0;
		rcv_cycle = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			rcv_cycle++;
			if (rcv_cycle % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_off_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= (rcv_cycle % 7) > 1;
					default: res_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// offer one tick item, bursts with random gaps between them
	task automatic send_tick(input logic pin, input logic edg);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				tick_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		tick_ch.valid <= 1'b1;
		tick_ch.pin_level <= pin;
		tick_ch.edge_seen <= edg;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// hold the pin for n ticks; edge flag on every change and now and then at random
	task automatic hold_level(input logic pin, input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			send_tick(pin, (pin != last_pin) || ($urandom_range(0, 5) == 0));
			last_pin = pin;
		end
	endtask

	// stop sending and wait until every tick has its result
	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write all three registers back to back while the block is idle
	task automatic write_all_regs(input logic [15:0] deb, input logic [15:0] lng,
		input logic [15:0] mc);
		logic [bcc_pkg::CFG_IDX_W-1:0] idx[3];
		logic [15:0] val[3];
		idx = '{bcc_pkg::REG_DEBOUNCE, bcc_pkg::REG_LONG_PRESS, bcc_pkg::REG_MULTICLICK};
		val = '{deb, lng, mc};
		drain_results();
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		cur_deb = (deb == 0) ? 1 : deb;
		cur_long = (lng == 0) ? 1 : lng;
		cur_mc = (mc == 0) ? 1 : mc;
	endtask

	// random gestures: click runs, long presses, bounces and noise
	task automatic run_gestures(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned kind;
		int unsigned n_clicks;
		stop_at = ticks_sent + n_items;
		while (ticks_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				n_clicks = $urandom_range(1, 5);
				for (int unsigned c = 0; c < n_clicks; c++) begin
					if ($urandom_range(0, 3) == 0) begin
						hold_level(1'b0, $urandom_range(1, cur_deb));
						hold_level(1'b1, $urandom_range(1, 2));
					end
					hold_level(1'b0, cur_deb + 1 + $urandom_range(0, cur_long - 1));
					if ($urandom_range(0, 4) == 0) begin
						hold_level(1'b1, $urandom_range(1, cur_deb));
						hold_level(1'b0, $urandom_range(1, 3));
					end
					if (c + 1 < n_clicks)
						hold_level(1'b1, cur_deb + 1 + $urandom_range(0, cur_mc + 1));
				end
				hold_level(1'b1, cur_deb + cur_mc + 3);
			end else if (kind <= 7) begin
				hold_level(1'b0, cur_deb + cur_long + $urandom_range(0, 5));
				hold_level(1'b1, cur_deb + 2);
			end else if (kind == 8) begin
				repeat ($urandom_range(5, 30))
					hold_level(1'($urandom_range(0, 1)), 1);
			end else begin
				// asleep ticks with no edge move nothing
				for (int unsigned i = 0; i < $urandom_range(2, 6); i++)
					send_tick(1'($urandom_range(0, 1)), 1'b0);
			end
		end
	endtask

	// asleep the block ignores the pin; an edge wakes it, a later edge is masked
	task automatic test_sleep_and_wake();
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
	endtask

	// one click with a zero debounce register, reported at once with multiclick one
	task automatic test_single_click();
		write_all_regs(16'd0, 16'd2, 16'd1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	// long press fires once, release puts the block to sleep
	task automatic test_long_press();
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	// receiver holds off while the sender keeps offering ticks
	task automatic test_output_stall();
		hold_off_req = 1'b1;
		run_gestures(60);
	endtask

	// random gestures over several register settings, with a full pause midway
	task automatic test_random_gestures();
		write_all_regs(16'd2, 16'd12, 16'd5);
		run_gestures(220);
		test_output_stall();
		write_all_regs(16'd3, 16'd25, 16'd8);
		run_gestures(220);
		write_all_regs(16'd1, 16'd1, 16'd1);
		run_gestures(150);
		write_all_regs(16'd4, 16'd40, 16'd20);
		run_gestures(120);
		drain_results();
		run_gestures(120);
	endtask

	// more than fifteen clicks saturate the count and give no event
	task automatic test_click_overflow();
		write_all_regs(16'd1, 16'd500, 16'd10);
		for (int i = 0; i < 18; i++) begin
			hold_level(1'b0, 3);
			hold_level(1'b1, 3);
		end
		hold_level(1'b1, 14);
	endtask

	// a press far below the largest long press setting ends as a single click
	task automatic test_long_threshold_unreached();
		write_all_regs(16'd1, 16'hFFFF, 16'd5);
		hold_level(1'b0, 40);
		hold_level(1'b1, 10);
	endtask

	// largest values in every register, a few ticks only
	task automatic test_register_extremes();
		write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		hold_level(1'b0, 6);
		hold_level(1'b1, 3);
		hold_level(1'b0, 4);
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.pin_level = 1'b1;
		tick_ch.edge_seen = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = bcc_pkg::REG_DEBOUNCE;
		cfg_ch.data = '0;
		errors = 0;
		ticks_sent = 0;
		results_checked = 0;
		burst_left = 0;
		last_pin = 1'b1;
		hold_off_req = 1'b0;
		cur_deb = bcc_pkg::DEBOUNCE_RST;
		cur_long = bcc_pkg::LONG_PRESS_RST;
		cur_mc = bcc_pkg::MULTICLICK_RST;
		for (int i = 0; i < 5; i++)
			event_counts[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sleep_and_wake();
		test_single_click();
		test_long_press();
		test_random_gestures();
		test_click_overflow();
		test_long_threshold_unreached();
		test_register_extremes();

		drain_results();
		repeat (5) @(posedge clk);
		$display("%0d ticks sent, %0d results checked over nine register settings",
			ticks_sent, results_checked);
		$display("events seen: long %0d, single %0d, double %0d, triple %0d",
			event_counts[bcc_pkg::EV_LONG], event_counts[bcc_pkg::EV_SINGLE],
			event_counts[bcc_pkg::EV_DOUBLE], event_counts[bcc_pkg::EV_TRIPLE]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results still expected", errors,
				pending_results.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
